// File: src/ffba_pkg.sv
package ffba_pkg;

	localparam int HEAP_BLOCKS     = 4096;
	localparam int MAX_ENTRIES_DEF = 32;

	localparam int SIZE_W = 13;
	localparam int BLK_W  = 12;
	localparam int END_W  = 14;

	localparam logic [END_W-1:0] HEAP_LAST = END_W'(HEAP_BLOCKS - 1);
	localparam logic [END_W-1:0] HEAP_FIRST = END_W'(1);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOFIT    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [SIZE_W-1:0] length;
		logic [BLK_W-1:0]  start;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SCAN,
		CMD_TAIL,
		CMD_UP,
		CMD_DOWN,
		CMD_FINISH
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t cmd;
		logic    set_result;
		status_t status;
	} dp_ctl_t;

	typedef struct packed {
		logic op_alloc;
		logic size_zero;
		logic full;
		logic empty;
		logic hit;
		logic last;
		logic tail_fit;
		logic at_pos;
	} dp_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_TAIL,
		S_UP,
		S_DOWN,
		S_FIN,
		S_RESP
	} ctrl_state_t;

endpackage

// File: src/first_fit_block_allocator.sv
// First-fit block allocator over a heap of HEAP_BLOCKS blocks, one block
// sentinel at each end. Requests enter on the s_ channel: s_tuser selects
// allocate or free, s_tdata carries the size in blocks and the start block
// to free. Each request yields exactly one word on the m_ channel: status
// in m_tuser, granted start block in m_tdata (zero unless an allocate
// succeeded).
// One request is in flight at a time; s_tready is high only while idle.
// m_tvalid rises after the check state for a request refused up front
// (zero size, full table, free on an empty table), with no search or shift.
// The search walks the entries up to the match and the shift walks the
// rest, one entry per cycle through the read and write ports of the entry
// table; on an allocate the matched entry is read again by the shift.
// s_tready returns in the cycle after the word is taken.
// Reset empties the table at once; there is no clearing pass.
// A stalled receiver holds the result word in place on m_tdata/m_tuser and
// keeps s_tready low until the word is taken.
module first_fit_block_allocator #(
	parameter int MAX_ENTRIES = ffba_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [12:0] size_blocks, [24:13] block_index
	input  logic [0:0]  s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [11:0] start_block
	output logic [1:0]  m_tuser    // [1:0] status
);

	ffba_pkg::dp_ctl_t             ctl;
	ffba_pkg::dp_stat_t            stat;
	ffba_pkg::status_t             res_status;
	logic [ffba_pkg::BLK_W-1:0]    res_start;

	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.ctl       (ctl)
	);

	ffba_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_op     (s_tuser[0]),
		.req_size   (s_tdata[12:0]),
		.req_index  (s_tdata[24:13]),
		.ctl        (ctl),
		.stat       (stat),
		.res_status (res_status),
		.res_start  (res_start)
	);

	assign m_tdata = {4'b0000, res_start};
	assign m_tuser = res_status;

endmodule

// File: src/ffba_ram.sv
module ffba_ram #(
	parameter int WIDTH = ffba_pkg::ENTRY_W,
	parameter int DEPTH = ffba_pkg::MAX_ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/ffba_dp.sv
module ffba_dp #(
	parameter int MAX_ENTRIES = ffba_pkg::MAX_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_op,
	input  logic [ffba_pkg::SIZE_W-1:0]    req_size,
	input  logic [ffba_pkg::BLK_W-1:0]     req_index,
	input  ffba_pkg::dp_ctl_t              ctl,
	output ffba_pkg::dp_stat_t             stat,
	output ffba_pkg::status_t              res_status,
	output logic [ffba_pkg::BLK_W-1:0]     res_start
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic                          op_q;
	logic [ffba_pkg::SIZE_W-1:0]   size_q;
	logic [ffba_pkg::BLK_W-1:0]    index_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 rd_ptr_q;
	logic [CW-1:0]                 chk_q;
	logic [CW-1:0]                 pos_q;
	logic                          data_v_q;
	logic [ffba_pkg::END_W-1:0]    prev_end_q;
	ffba_pkg::status_t             status_q;
	logic [ffba_pkg::BLK_W-1:0]    start_q;

	ffba_pkg::entry_t              rdata;
	ffba_pkg::entry_t              wdata;
	logic [ffba_pkg::ENTRY_W-1:0]  rdata_raw;
	logic                          we;
	logic [IW-1:0]                 waddr;

	logic [ffba_pkg::END_W-1:0]    ent_start;
	logic [ffba_pkg::END_W-1:0]    ent_end;
	logic [ffba_pkg::END_W-1:0]    need;
	logic [CW-1:0]                 count_m1;
	logic [CW-1:0]                 chk_inc;
	logic [CW-1:0]                 chk_dec;
	logic                          gap_ok;
	logic                          hit;

	ffba_ram #(
		.WIDTH (ffba_pkg::ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_ptr_q[IW-1:0]),
		.rdata (rdata_raw)
	);

	assign rdata     = ffba_pkg::entry_t'(rdata_raw);
	assign ent_start = {{(ffba_pkg::END_W - ffba_pkg::BLK_W){1'b0}}, rdata.start};
	assign ent_end   = ent_start + {{(ffba_pkg::END_W - ffba_pkg::SIZE_W){1'b0}}, rdata.length};
	assign need      = {{(ffba_pkg::END_W - ffba_pkg::SIZE_W){1'b0}}, size_q};
	assign count_m1  = count_q - CW'(1);
	assign chk_inc   = chk_q + CW'(1);
	assign chk_dec   = chk_q - CW'(1);
	assign gap_ok    = (ent_start > prev_end_q) && ((ent_start - prev_end_q) >= need);
	assign hit       = data_v_q && ((op_q == ffba_pkg::OP_ALLOC) ? gap_ok
	                                                             : (rdata.start == index_q));

	always_comb begin
		stat.op_alloc  = (op_q == ffba_pkg::OP_ALLOC);
		stat.size_zero = (size_q == '0);
		stat.full      = (count_q == CW'(MAX_ENTRIES));
		stat.empty     = (count_q == '0);
		stat.hit       = hit;
		stat.last      = data_v_q && (chk_q == count_m1);
		stat.tail_fit  = (ffba_pkg::HEAP_LAST > prev_end_q)
		                 && ((ffba_pkg::HEAP_LAST - prev_end_q) >= need);
		stat.at_pos    = data_v_q && (chk_q == pos_q);
	end

	always_comb begin
		we    = 1'b0;
		waddr = chk_q[IW-1:0];
		wdata = rdata;
		unique case (ctl.cmd)
			ffba_pkg::CMD_UP: begin
				we    = data_v_q;
				waddr = chk_inc[IW-1:0];
			end
			ffba_pkg::CMD_DOWN: begin
				we    = data_v_q;
				waddr = chk_dec[IW-1:0];
			end
			ffba_pkg::CMD_FINISH: begin
				we           = (op_q == ffba_pkg::OP_ALLOC);
				waddr        = pos_q[IW-1:0];
				wdata.start  = prev_end_q[ffba_pkg::BLK_W-1:0];
				wdata.length = size_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.cmd == ffba_pkg::CMD_LOAD) begin
			op_q    <= req_op;
			size_q  <= req_size;
			index_q <= req_index;
		end
		if (ctl.set_result) begin
			status_q <= ctl.status;
			start_q  <= '0;
		end else if (ctl.cmd == ffba_pkg::CMD_FINISH) begin
			status_q <= ffba_pkg::ST_OK;
			start_q  <= (op_q == ffba_pkg::OP_ALLOC) ? prev_end_q[ffba_pkg::BLK_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			rd_ptr_q   <= '0;
			chk_q      <= '0;
			pos_q      <= '0;
			data_v_q   <= 1'b0;
			prev_end_q <= ffba_pkg::HEAP_FIRST;
		end else begin
			unique case (ctl.cmd)
				ffba_pkg::CMD_LOAD: begin
					rd_ptr_q   <= '0;
					data_v_q   <= 1'b0;
					prev_end_q <= ffba_pkg::HEAP_FIRST;
				end
				ffba_pkg::CMD_SCAN: begin
					if (hit) begin
						pos_q    <= chk_q;
						data_v_q <= 1'b0;
						rd_ptr_q <= (op_q == ffba_pkg::OP_ALLOC) ? count_m1 : chk_inc;
					end else begin
						data_v_q <= 1'b1;
						chk_q    <= rd_ptr_q;
						rd_ptr_q <= rd_ptr_q + CW'(1);
						if (data_v_q) begin
							prev_end_q <= ent_end;
						end
					end
				end
				ffba_pkg::CMD_TAIL: begin
					pos_q <= count_q;
				end
				ffba_pkg::CMD_UP: begin
					data_v_q <= 1'b1;
					chk_q    <= rd_ptr_q;
					rd_ptr_q <= rd_ptr_q - CW'(1);
				end
				ffba_pkg::CMD_DOWN: begin
					data_v_q <= 1'b1;
					chk_q    <= rd_ptr_q;
					rd_ptr_q <= rd_ptr_q + CW'(1);
				end
				ffba_pkg::CMD_FINISH: begin
					count_q <= (op_q == ffba_pkg::OP_ALLOC) ? count_q + CW'(1)
					                                        : count_q - CW'(1);
				end
				default: begin
					data_v_q <= data_v_q;
				end
			endcase
		end
	end

	assign res_status = status_q;
	assign res_start  = start_q;

endmodule

// File: src/ffba_ctrl.sv
module ffba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ffba_pkg::dp_stat_t  stat,
	output ffba_pkg::dp_ctl_t   ctl
);

	ffba_pkg::ctrl_state_t state_q;
	ffba_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		ctl.cmd        = ffba_pkg::CMD_NONE;
		ctl.set_result = 1'b0;
		ctl.status     = ffba_pkg::ST_OK;
		unique case (state_q)
			ffba_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.cmd = ffba_pkg::CMD_LOAD;
					state_d = ffba_pkg::S_CHECK;
				end
			end
			ffba_pkg::S_CHECK: begin
				if (stat.op_alloc && stat.size_zero) begin
					ctl.set_result = 1'b1;
					ctl.status     = ffba_pkg::ST_NOFIT;
					state_d        = ffba_pkg::S_RESP;
				end else if (stat.op_alloc && stat.full) begin
					ctl.set_result = 1'b1;
					ctl.status     = ffba_pkg::ST_FULL;
					state_d        = ffba_pkg::S_RESP;
				end else if (stat.empty) begin
					if (stat.op_alloc) begin
						state_d = ffba_pkg::S_TAIL;
					end else begin
						ctl.set_result = 1'b1;
						ctl.status     = ffba_pkg::ST_NOTFOUND;
						state_d        = ffba_pkg::S_RESP;
					end
				end else begin
					ctl.cmd = ffba_pkg::CMD_SCAN;
					state_d = ffba_pkg::S_SCAN;
				end
			end
			ffba_pkg::S_SCAN: begin
				ctl.cmd = ffba_pkg::CMD_SCAN;
				if (stat.hit) begin
					if (stat.op_alloc) begin
						state_d = ffba_pkg::S_UP;
					end else if (stat.last) begin
						state_d = ffba_pkg::S_FIN;
					end else begin
						state_d = ffba_pkg::S_DOWN;
					end
				end else if (stat.last) begin
					if (stat.op_alloc) begin
						state_d = ffba_pkg::S_TAIL;
					end else begin
						ctl.set_result = 1'b1;
						ctl.status     = ffba_pkg::ST_NOTFOUND;
						state_d        = ffba_pkg::S_RESP;
					end
				end
			end
			ffba_pkg::S_TAIL: begin
				ctl.cmd = ffba_pkg::CMD_TAIL;
				if (stat.tail_fit) begin
					state_d = ffba_pkg::S_FIN;
				end else begin
					ctl.set_result = 1'b1;
					ctl.status     = ffba_pkg::ST_NOFIT;
					state_d        = ffba_pkg::S_RESP;
				end
			end
			ffba_pkg::S_UP: begin
				ctl.cmd = ffba_pkg::CMD_UP;
				if (stat.at_pos) begin
					state_d = ffba_pkg::S_FIN;
				end
			end
			ffba_pkg::S_DOWN: begin
				ctl.cmd = ffba_pkg::CMD_DOWN;
				if (stat.last) begin
					state_d = ffba_pkg::S_FIN;
				end
			end
			ffba_pkg::S_FIN: begin
				ctl.cmd = ffba_pkg::CMD_FINISH;
				state_d = ffba_pkg::S_RESP;
			end
			ffba_pkg::S_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ffba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffba_pkg::S_IDLE;
			end
		endcase
	end

endmodule
